[rtl/core/hdr_pkg.sv]
// Package for the heading dead-reckoning block: widths, CORDIC arctangent
// table and controller state type. No dependencies.
package hdr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 48;
    localparam int CORDIC_STEPS   = 24;
    localparam int STEP_BITS      = 5;
    localparam int CW             = 64;
    localparam logic [31:0] HALF_TURN32    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN32 = 32'h4000_0000;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_YAW,
        ST_ROT_PREP,
        ST_ROT,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic yaw_step;
        logic rot_prep;
        logic rot_step;
        logic mul;
        logic acc;
    } cmd_t;

    typedef struct packed {
        logic last_step;
    } sts_t;

    // atan(2^-i) with one turn = 2^32.
    function automatic logic [31:0] atan_tab(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/core/hdr_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on nothing.
interface hdr_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] fwd_speed;
    logic [19:0] elapsed_us;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, fwd_speed, elapsed_us,
                    input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, fwd_speed, elapsed_us,
                  output ready);
endinterface

interface hdr_out_if;
    logic valid;
    logic ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] rel_heading;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, rel_heading, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, rel_heading, output ready);
endinterface

[rtl/core/hdr_ctrl.sv]
// Controller for the heading dead-reckoning block: sequences the two CORDIC
// passes, the multiply and the accumulate. Depends on hdr_pkg.
module hdr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  hdr_pkg::sts_t   sts,
    output hdr_pkg::cmd_t   cmd
);

    hdr_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            hdr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = hdr_pkg::ST_PREP;
                end
            end
            hdr_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = hdr_pkg::ST_YAW;
            end
            hdr_pkg::ST_YAW:
            begin
                cmd.yaw_step = 1'b1;
                if (sts.last_step)
                begin
                    state_next = hdr_pkg::ST_ROT_PREP;
                end
            end
            hdr_pkg::ST_ROT_PREP:
            begin
                cmd.rot_prep = 1'b1;
                state_next = hdr_pkg::ST_ROT;
            end
            hdr_pkg::ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (sts.last_step)
                begin
                    state_next = hdr_pkg::ST_MUL;
                end
            end
            hdr_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = hdr_pkg::ST_ACC;
            end
            hdr_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = hdr_pkg::ST_OUT;
            end
            hdr_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = hdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hdr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A request is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output both open");
    // A load always starts a yaw pass.
    a_load_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.prep) else $error("load not followed by prep");
    // The accumulate is followed by a pending result.
    a_acc_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |=> out_valid) else $error("accumulate not followed by result");
`endif

endmodule

[rtl/core/hdr_dp.sv]
// Datapath for the heading dead-reckoning block: shared CORDIC unit, the
// velocity multiply and saturating accumulators. Depends on hdr_pkg.
module hdr_dp #(
    parameter int ANGLE_BITS = hdr_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = hdr_pkg::POS_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hdr_pkg::cmd_t       cmd,
    output hdr_pkg::sts_t       sts,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  fwd_speed,
    input  logic [19:0]         elapsed_us,
    output logic signed [47:0]  pos_x,
    output logic signed [47:0]  pos_y,
    output logic signed [15:0]  vel_x,
    output logic signed [15:0]  vel_y,
    output logic signed [15:0]  rel_heading
);

    localparam int CW   = hdr_pkg::CW;
    localparam int DROP = 32 - ANGLE_BITS;
    localparam int SW   = ((POS_BITS > 37) ? POS_BITS : 37) + 2;
    localparam logic signed [POS_BITS-1:0] MAXV = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] MINV = {1'b1, {(POS_BITS-1){1'b0}}};

    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg, spd_reg;
    logic [19:0] dt_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0] z_reg;
    logic [hdr_pkg::STEP_BITS-1:0] step_reg;
    logic started_reg;
    logic [ANGLE_BITS-1:0] start_reg, rel_reg;
    logic signed [15:0] vx_reg, vy_reg;
    logic signed [POS_BITS-1:0] accx_reg, accy_reg;

    logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
    logic signed [47:0] gain_prod;
    logic signed [CW-1:0] num, den, sx, sy;
    logic [31:0] atn, zq, rel32;
    logic [ANGLE_BITS-1:0] yaw, rel_new;
    logic y_pos, a_pos, flip;
    logic signed [CW-1:0] vx_full, vy_full;
    logic signed [36:0] px, py;

    // Quaternion products that form the yaw vector, each 16 by 16 bits.
    assign p_wz = qw_reg * qz_reg;
    assign p_xy = qx_reg * qy_reg;
    assign p_yy = qy_reg * qy_reg;
    assign p_zz = qz_reg * qz_reg;
    assign num = 2 * (CW'(p_wz) + CW'(p_xy));
    assign den = (CW'(1) <<< 28) - 2 * (CW'(p_yy) + CW'(p_zz));

    // Speed scaled by the inverse CORDIC gain, 16 by 32 bits.
    assign gain_prod = spd_reg * hdr_pkg::CORDIC_GAIN_Q30;

    assign sx  = cx_reg >>> step_reg;
    assign sy  = cy_reg >>> step_reg;
    assign atn = hdr_pkg::atan_tab(step_reg);
    assign y_pos = (cy_reg > 0);
    assign a_pos = !z_reg[31];
    assign sts.last_step = (step_reg == 5'(hdr_pkg::CORDIC_STEPS - 1));

    // Yaw rounding and relative heading; the angle is folded into the right
    // half-plane when it lies beyond a quarter turn either way.
    assign zq  = z_reg + (32'd1 << (DROP - 1));
    assign yaw = zq[31 -: ANGLE_BITS];
    assign rel_new = yaw - (started_reg ? start_reg : yaw);
    assign rel32 = {rel_new, {DROP{1'b0}}};
    assign flip = rel32[31] ^ rel32[30];

    assign vx_full = (cx_reg + (CW'(1) <<< 29)) >>> 30;
    assign vy_full = (cy_reg + (CW'(1) <<< 29)) >>> 30;

    // Velocity times elapsed time, one 16x21 product per axis.
    assign px = 37'(vx_reg) * $signed({17'd0, dt_reg});
    assign py = 37'(vy_reg) * $signed({17'd0, dt_reg});

    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        begin
            if (v > 32767)
                return 16'sh7fff;
            else if (v < -32768)
                return -16'sh8000;
            else
                return v[15:0];
        end
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_add(
        input logic signed [POS_BITS-1:0] a, input logic signed [36:0] d);
        logic signed [SW-1:0] s;
        begin
            s = SW'(a) + SW'(d);
            if (s > SW'(MAXV))
                return MAXV;
            else if (s < SW'(MINV))
                return MINV;
            else
                return s[POS_BITS-1:0];
        end
    endfunction

    // Control-bearing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            start_reg   <= '0;
            accx_reg    <= '0;
            accy_reg    <= '0;
        end
        else
        begin
            if (cmd.rot_prep && !started_reg)
            begin
                started_reg <= 1'b1;
                start_reg   <= yaw;
            end
            if (cmd.acc)
            begin
                accx_reg <= sat_add(accx_reg, px);
                accy_reg <= sat_add(accy_reg, py);
            end
        end
    end

    // Working registers of the shared CORDIC and multiplier.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
            spd_reg <= fwd_speed;
            dt_reg <= elapsed_us;
        end
        if (cmd.prep)
        begin
            step_reg <= '0;
            if (den < 0)
            begin
                cx_reg <= -den;
                cy_reg <= -num;
                z_reg  <= hdr_pkg::HALF_TURN32;
            end
            else
            begin
                cx_reg <= den;
                cy_reg <= num;
                z_reg  <= '0;
            end
            // Zero numerator: fixed answer, freeze the CORDIC by x = y = 0.
            if (num == 0)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                z_reg  <= (den < 0) ? hdr_pkg::HALF_TURN32 : 32'd0;
            end
        end
        if (cmd.yaw_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (num == 0)
            begin
                z_reg <= z_reg;
            end
            else if (y_pos)
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                z_reg  <= z_reg + atn;
            end
            else
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                z_reg  <= z_reg - atn;
            end
        end
        // Set up the rotation: relative heading, folded angle and scaled speed.
        if (cmd.rot_prep)
        begin
            step_reg <= '0;
            rel_reg  <= rel_new;
            cy_reg   <= '0;
            if (flip)
            begin
                cx_reg <= -CW'(gain_prod);
                z_reg  <= rel32 + hdr_pkg::HALF_TURN32;
            end
            else
            begin
                cx_reg <= CW'(gain_prod);
                z_reg  <= rel32;
            end
        end
        if (cmd.rot_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (a_pos)
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                z_reg  <= z_reg - atn;
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                z_reg  <= z_reg + atn;
            end
        end
        if (cmd.mul)
        begin
            vx_reg <= sat16(vx_full);
            vy_reg <= sat16(vy_full);
        end
    end

    always_comb
    begin
        pos_x = 48'(accx_reg);
        pos_y = 48'(accy_reg);
        vel_x = vx_reg;
        vel_y = vy_reg;
        if (ANGLE_BITS >= 16)
            rel_heading = 16'(rel_reg >> (ANGLE_BITS - 16));
        else
            rel_heading = 16'({rel_reg, 8'd0} >> (ANGLE_BITS - 8));
    end

endmodule

[rtl/core/heading_dead_reckoning.sv]
// Heading dead-reckoning top level: controller plus datapath.
// From request accepted to result valid: two 24-step CORDIC passes on
// one shared unit, each after its own set-up state, then velocity
// scaling and accumulate. One item in flight: a new request is taken
// only after the result has been accepted.
// Reset (rst_n, asynchronous): clears start flag, start heading, position.
module heading_dead_reckoning #(
    parameter int ANGLE_BITS = hdr_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = hdr_pkg::POS_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    hdr_in_if.sink    sample,
    hdr_out_if.source result
);

    hdr_pkg::cmd_t cmd;
    hdr_pkg::sts_t sts;

    hdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hdr_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .quat_x      (sample.quat_x),
        .quat_y      (sample.quat_y),
        .quat_z      (sample.quat_z),
        .quat_w      (sample.quat_w),
        .fwd_speed   (sample.fwd_speed),
        .elapsed_us  (sample.elapsed_us),
        .pos_x       (result.pos_x),
        .pos_y       (result.pos_y),
        .vel_x       (result.vel_x),
        .vel_y       (result.vel_y),
        .rel_heading (result.rel_heading)
    );

endmodule
